// ===== hdl/ufd_pkg.sv =====
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared codes and types for the header/length frame deframer with checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package ufd_pkg;

	localparam int unsigned PhaseW = 3;
	localparam int unsigned KindW  = 2;
	localparam int unsigned LenW   = 16;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned AddrW  = 2;

	// parser phases
	localparam logic [PhaseW-1:0] PH_HUNT_FIRST  = 3'd0;
	localparam logic [PhaseW-1:0] PH_HUNT_SECOND = 3'd1;
	localparam logic [PhaseW-1:0] PH_LENGTH      = 3'd2;
	localparam logic [PhaseW-1:0] PH_EXT_HIGH    = 3'd3;
	localparam logic [PhaseW-1:0] PH_EXT_LOW     = 3'd4;
	localparam logic [PhaseW-1:0] PH_PAYLOAD     = 3'd5;
	localparam logic [PhaseW-1:0] PH_CHECK       = 3'd6;

	// result kinds
	localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KindW-1:0] KIND_GOOD    = 2'd1;
	localparam logic [KindW-1:0] KIND_BAD     = 2'd2;

	// register indexes
	localparam logic [AddrW-1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [AddrW-1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [AddrW-1:0] REG_CHECK_ENABLE  = 2'd2;

	localparam logic [ByteW-1:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [ByteW-1:0] HEADER_SECOND_RST = 8'h55;

	typedef struct packed {
		logic [ByteW-1:0] header_first;
		logic [ByteW-1:0] header_second;
		logic             check_enable;
	} cfg_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] payload_byte;
		logic [LenW-1:0]  frame_payload_len;
		logic             extended_len;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/ufd_byte_if.sv =====
// ----------------------------------------------------------------------------
// ufd_byte_if
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/ufd_result_if.sv =====
// ----------------------------------------------------------------------------
// ufd_result_if
// Valid/ready channel carrying one parser result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [15:0] frame_payload_len;
	logic        extended_len;

	modport source (output valid, output kind, output payload_byte,
		output frame_payload_len, output extended_len, input ready);
	modport sink (input valid, input kind, input payload_byte,
		input frame_payload_len, input extended_len, output ready);
endinterface

`default_nettype wire

// ===== hdl/ufd_cfg.sv =====
// ----------------------------------------------------------------------------
// ufd_cfg
// Configuration registers: header bytes and checksum enable.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_cfg
	import ufd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [AddrW-1:0] cfg_addr,
	input  wire logic [ByteW-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= HEADER_FIRST_RST;
			cfg_q.header_second <= HEADER_SECOND_RST;
			cfg_q.check_enable  <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata;
				REG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata;
				REG_CHECK_ENABLE:  cfg_q.check_enable  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/ufd_parse.sv =====
// ----------------------------------------------------------------------------
// ufd_parse
// Frame parser state: header hunt, length, payload sum and checksum verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_parse
	import ufd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             step,
	input  wire logic [ByteW-1:0] rx_byte,
	output logic                  has_result,
	output result_t               res
);

	logic [PhaseW-1:0] phase_q, phase_d;
	logic [LenW-1:0]   remain_q, remain_d;
	logic [LenW-1:0]   len_q, len_d;
	logic [ByteW-1:0]  sum_q, sum_d;
	logic              ext_q, ext_d;
	logic [LenW-1:0]   remain_dec;
	logic [LenW-1:0]   ext_len;
	logic [ByteW-1:0]  expect_sum;

	assign remain_dec = remain_q - 16'd1;
	assign ext_len    = {len_q[LenW-1:ByteW], rx_byte};
	assign expect_sum = 8'd0 - sum_q;

	always_comb begin
		phase_d    = phase_q;
		remain_d   = remain_q;
		len_d      = len_q;
		sum_d      = sum_q;
		ext_d      = ext_q;
		has_result = 1'b0;
		res.kind              = KIND_PAYLOAD;
		res.payload_byte      = '0;
		res.frame_payload_len = len_q;
		res.extended_len      = ext_q;
		unique case (phase_q)
			PH_HUNT_FIRST: begin
				if (rx_byte == cfg.header_first) phase_d = PH_HUNT_SECOND;
			end
			PH_HUNT_SECOND: begin
				if (rx_byte == cfg.header_second) begin
					phase_d = PH_LENGTH;
					sum_d   = '0;
				end else if (rx_byte != cfg.header_first) begin
					phase_d = PH_HUNT_FIRST;
				end
			end
			PH_LENGTH: begin
				if (rx_byte == '0) begin
					ext_d   = 1'b1;
					phase_d = PH_EXT_HIGH;
				end else begin
					ext_d    = 1'b0;
					len_d    = {{(LenW-ByteW){1'b0}}, rx_byte};
					remain_d = {{(LenW-ByteW){1'b0}}, rx_byte};
					phase_d  = PH_PAYLOAD;
				end
			end
			PH_EXT_HIGH: begin
				len_d   = {rx_byte, {ByteW{1'b0}}};
				phase_d = PH_EXT_LOW;
			end
			PH_EXT_LOW: begin
				len_d    = ext_len;
				remain_d = ext_len;
				phase_d  = (ext_len == '0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_d      = sum_q + rx_byte;
				remain_d   = remain_dec;
				if (remain_dec == '0) phase_d = PH_CHECK;
				has_result = 1'b1;
				res.payload_byte = rx_byte;
			end
			PH_CHECK: begin
				phase_d    = PH_HUNT_FIRST;
				has_result = 1'b1;
				res.kind   = (!cfg.check_enable || expect_sum == rx_byte) ?
					KIND_GOOD : KIND_BAD;
			end
			default: phase_d = PH_HUNT_FIRST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT_FIRST;
			remain_q <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			ext_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			len_q    <= len_d;
			sum_q    <= sum_d;
			ext_q    <= ext_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/uart_frame_deframer_checksum.sv =====
// ----------------------------------------------------------------------------
// uart_frame_deframer_checksum
// Header/length frame deframer with two's complement trailing checksum.
// ----------------------------------------------------------------------------
// path: a byte is registered at the input (byte_s1), parsed, and its result lands in
// the output register (res_s2), which drives result.valid and the result fields
// throughput: one byte per cycle, unless a byte with a result waits on a stalled output
// reset: arst_n clears parser state and both stage valid flags; registers take defaults
`default_nettype none

module uart_frame_deframer_checksum
	import ufd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [AddrW-1:0] cfg_addr,
	input  wire logic [ByteW-1:0] cfg_wdata,
	ufd_byte_if.sink              rx,
	ufd_result_if.source          result
);

	cfg_t             cfg;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             valid_s2;
	result_t          res_s2;
	logic             has_result;
	result_t          res;
	logic             out_free;
	logic             advance;

	ufd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ufd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (advance),
		.rx_byte    (byte_s1),
		.has_result (has_result),
		.res        (res)
	);

	// a byte with no result never waits on the output side
	assign out_free = !valid_s2 || result.ready;
	assign advance  = valid_s1 && (!has_result || out_free);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) byte_s1 <= rx.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) res_s2 <= res;
	end

	assign result.valid             = valid_s2;
	assign result.kind              = res_s2.kind;
	assign result.payload_byte      = res_s2.payload_byte;
	assign result.frame_payload_len = res_s2.frame_payload_len;
	assign result.extended_len      = res_s2.extended_len;

endmodule

`default_nettype wire
